// File: src/cce_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cce_pkg
// shared widths, codes and controller/datapath interface types for the
// circular 2d convolution engine
// ----------------------------------------------------------------------------
package cce_pkg;

    // field widths
    localparam int OP_W      = 2;
    localparam int IDX_W     = 6;
    localparam int VAL_W     = 16;
    localparam int DIM_W     = 7;
    localparam int OUT_W     = 24;
    localparam int PROD_W    = 2 * VAL_W;
    // 127 x 127 products of at most 2^30 need 44 bits plus sign and margin
    localparam int ACC_W     = 46;
    localparam int FRAC_W    = 15;
    localparam int CFG_IDX_W = 1;

    // opcodes
    localparam logic [OP_W-1:0] OP_WR_KERNEL = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_GRID   = 2'd1;
    localparam logic [OP_W-1:0] OP_READ      = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    // rounding and output range
    localparam logic signed [ACC_W-1:0] ROUND_HALF  = 46'sd16384;
    localparam logic signed [ACC_W-1:0] OUT_MAX_ACC = 46'sd8388607;
    localparam logic signed [ACC_W-1:0] OUT_MIN_ACC = -46'sd8388608;
    localparam logic [OUT_W-1:0]        OUT_MAX_VAL = 24'h7FFFFF;
    localparam logic [OUT_W-1:0]        OUT_MIN_VAL = 24'h800000;

    typedef struct packed {
        logic wr_kernel;
        logic wr_grid;
        logic load_idx;
        logic mod_step;
        logic start_scan;
        logic step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic mod_done;
        logic scan_last;
        logic pipe_busy;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

// File: src/cce_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cce_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module cce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

// File: src/cce_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cce_ctrl
// request sequencer: decodes requests, walks index reduction, the
// multiply-accumulate scan, pipeline drain and result hand-off
// ----------------------------------------------------------------------------
module cce_ctrl
    import cce_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_tvalid,
    input  wire logic [OP_W-1:0] i_opcode,
    output logic                 o_s_tready,
    input  wire t_status         i_st,
    output t_cmd                 o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MOD   = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    unique case (i_opcode)
                        OP_WR_KERNEL: o_cmd.wr_kernel = 1'b1;
                        OP_WR_GRID:   o_cmd.wr_grid   = 1'b1;
                        OP_READ: begin
                            o_cmd.load_idx = 1'b1;
                            n_state        = S_MOD;
                        end
                        default: ;
                    endcase
                end
            end
            S_MOD: begin
                if (i_st.mod_done) begin
                    o_cmd.start_scan = 1'b1;
                    n_state          = S_SCAN;
                end else begin
                    o_cmd.mod_step = 1'b1;
                end
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_st.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_st.pipe_busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // hold the finished sum until the output register frees up
                if (i_st.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_read_starts_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_opcode == OP_READ) |=> (r_state == S_MOD))
        else $error("read request did not start index reduction");

endmodule
`default_nettype wire

// File: src/cce_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cce_datapath
// configuration registers, kernel and grid stores, scan counters,
// multiply-accumulate pipeline, rounding, saturation and output register
// ----------------------------------------------------------------------------
module cce_datapath
    import cce_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    output t_status                   o_st,
    input  wire logic [IDX_W-1:0]     i_row_index,
    input  wire logic [IDX_W-1:0]     i_col_index,
    input  wire logic [VAL_W-1:0]     i_cell_value,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DIM_W-1:0]     i_cfg_data,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output logic      [OUT_W-1:0]     o_conv_value,
    output logic                      o_saturated
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);

    logic [DIM_W-1:0] r_rows;
    logic [DIM_W-1:0] r_cols;
    logic [DIM_W-1:0] dim_r;
    logic [DIM_W-1:0] dim_c;

    logic [DIM_W-1:0] r_rr;
    logic [DIM_W-1:0] r_cc;
    logic [DIM_W-1:0] r_a;
    logic [DIM_W-1:0] r_b;
    logic [DIM_W-1:0] r_ka;
    logic [DIM_W-1:0] r_kb;
    logic [DIM_W-1:0] r_kb0;

    logic                    wr_ok;
    logic [AW-1:0]           wr_addr;
    logic [AW-1:0]           grid_addr;
    logic [AW-1:0]           kern_addr;
    logic [VAL_W-1:0]        grid_data;
    logic [VAL_W-1:0]        kern_data;

    logic                     r_v1;
    logic                     r_v2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  rnd_sum;
    logic signed [ACC_W-1:0]  rnd_shift;

    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_value;
    logic             r_out_sat;
    logic [OUT_W-1:0] sat_value;
    logic             sat_flag;

    // a zero dimension acts as one, anything beyond the store as the store size
    always_comb begin
        if (r_rows == '0) begin
            dim_r = DIM_W'(1);
        end else if (int'(r_rows) > MAX_ROWS) begin
            dim_r = DIM_W'(MAX_ROWS);
        end else begin
            dim_r = r_rows;
        end
        if (r_cols == '0) begin
            dim_c = DIM_W'(1);
        end else if (int'(r_cols) > MAX_COLS) begin
            dim_c = DIM_W'(MAX_COLS);
        end else begin
            dim_c = r_cols;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= DIM_RESET;
            r_cols <= DIM_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROWS: r_rows <= i_cfg_data;
                CFG_COLS: r_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stores
    assign wr_ok     = (int'(i_row_index) < MAX_ROWS) && (int'(i_col_index) < MAX_COLS);
    assign wr_addr   = AW'(i_row_index) * AW'(MAX_COLS) + AW'(i_col_index);
    assign grid_addr = AW'(r_a) * AW'(MAX_COLS) + AW'(r_b);
    assign kern_addr = AW'(r_ka) * AW'(MAX_COLS) + AW'(r_kb);

    cce_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_kernel_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_kernel && wr_ok),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_cell_value),
        .i_rd_addr (kern_addr),
        .o_rd_data (kern_data)
    );

    cce_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_grid_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_grid && wr_ok),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_cell_value),
        .i_rd_addr (grid_addr),
        .o_rd_data (grid_data)
    );

    // index reduction and scan counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_idx) begin
            r_rr <= DIM_W'(i_row_index);
            r_cc <= DIM_W'(i_col_index);
        end else if (i_cmd.mod_step) begin
            if (r_rr >= dim_r) begin
                r_rr <= r_rr - dim_r;
            end
            if (r_cc >= dim_c) begin
                r_cc <= r_cc - dim_c;
            end
        end

        if (i_cmd.start_scan) begin
            r_a   <= '0;
            r_b   <= '0;
            // kernel walk starts one cell behind the requested one
            r_ka  <= (r_rr == '0) ? dim_r - 1'b1 : r_rr - 1'b1;
            r_kb  <= (r_cc == '0) ? dim_c - 1'b1 : r_cc - 1'b1;
            r_kb0 <= (r_cc == '0) ? dim_c - 1'b1 : r_cc - 1'b1;
        end else if (i_cmd.step) begin
            if (r_b == dim_c - 1'b1) begin
                r_b  <= '0;
                r_kb <= r_kb0;
                r_a  <= r_a + 1'b1;
                r_ka <= (r_ka == '0) ? dim_r - 1'b1 : r_ka - 1'b1;
            end else begin
                r_b  <= r_b + 1'b1;
                r_kb <= (r_kb == '0) ? dim_c - 1'b1 : r_kb - 1'b1;
            end
        end
    end

    // multiply-accumulate pipeline: ram read, product, accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.step;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= $signed(grid_data) * $signed(kern_data);
        if (i_cmd.start_scan) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // round half up then saturate to q9.15
    assign rnd_sum   = r_acc + ROUND_HALF;
    assign rnd_shift = rnd_sum >>> FRAC_W;

    always_comb begin
        if (rnd_shift > OUT_MAX_ACC) begin
            sat_value = OUT_MAX_VAL;
            sat_flag  = 1'b1;
        end else if (rnd_shift < OUT_MIN_ACC) begin
            sat_value = OUT_MIN_VAL;
            sat_flag  = 1'b1;
        end else begin
            sat_value = rnd_shift[OUT_W-1:0];
            sat_flag  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_value <= sat_value;
            r_out_sat   <= sat_flag;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_conv_value = r_out_value;
    assign o_saturated  = r_out_sat;

    assign o_st.mod_done  = (r_rr < dim_r) && (r_cc < dim_c);
    assign o_st.scan_last = (r_a == dim_r - 1'b1) && (r_b == dim_c - 1'b1);
    assign o_st.pipe_busy = r_v1 || r_v2;
    assign o_st.out_free  = !r_out_valid || i_out_ready;

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_a < dim_r && r_b < dim_c && r_ka < dim_r && r_kb < dim_c))
        else $error("scan index outside active area");

    a_sat_is_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_sat) |-> (r_out_value == OUT_MAX_VAL ||
                                        r_out_value == OUT_MIN_VAL))
        else $error("saturated result is not a range limit");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> r_out_valid)
        else $error("result load did not raise output valid");

endmodule
`default_nettype wire

// File: src/circular_conv2d_engine_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// circular_conv2d_engine_core
// toroidal 2d convolution of a stored grid with a stored kernel, exact sum
// ----------------------------------------------------------------------------
// input stream: tuser carries the opcode (write kernel cell, write grid cell,
// read result); tdata carries row, column and the q1.15 cell value.
// writes produce no output; writes outside the store are
// dropped. a read returns the q9.15 convolution value at (row, col) on the
// output stream, with tuser set when the sum was clipped.
// configuration: rows_in_use (index 0) and cols_in_use (index 1) set the
// wrap moduli R and C; write them only while no request is in flight.
// a read first reduces row and col modulo R and C by repeated subtraction,
// then starts the scan and walks all R * C cells, then drains the pipeline
// and hands off the result; the scan does one multiply-accumulate per cycle
// through the single read port of each store.
// one request is worked at a time; a finished result sits in the output
// register so the next request is taken while the receiver stalls, and a
// second read waits at its end until that register is free.
// reset sets both dimensions to 64; stores are not cleared and must be
// written before the cells they hold are used.
// ----------------------------------------------------------------------------
module circular_conv2d_engine_core
    import cce_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [31:0]          s_axis_tdata,   // row_index, col_index, cell_value, zero pad
    input  wire logic [OP_W-1:0]      s_axis_tuser,   // opcode
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [OUT_W-1:0]     m_axis_tdata,   // conv_value
    output logic      [0:0]           m_axis_tuser,   // saturated
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DIM_W-1:0]     i_cfg_data
);

    t_cmd    cmd;
    t_status st;

    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] col_index;
    logic [VAL_W-1:0] cell_value;
    logic             sat_bit;

    assign row_index  = s_axis_tdata[IDX_W-1:0];
    assign col_index  = s_axis_tdata[2*IDX_W-1:IDX_W];
    assign cell_value = s_axis_tdata[2*IDX_W+VAL_W-1:2*IDX_W];

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tuser = sat_bit;

    cce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_opcode   (s_axis_tuser),
        .o_s_tready (s_axis_tready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    cce_datapath #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_st         (st),
        .i_row_index  (row_index),
        .i_col_index  (col_index),
        .i_cell_value (cell_value),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_conv_value (m_axis_tdata),
        .o_saturated  (sat_bit)
    );

endmodule
`default_nettype wire
